@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Both macros sample on the rising edge of clk and are quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMPL(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/mvhp_pkg.sv @@
`timescale 1ns / 1ps

package mvhp_pkg;

  // Packet kinds carried with every input byte.
  typedef enum logic [1:0] {
    FUNC_CONNACK = 2'd0,
    FUNC_PUBLISH = 2'd1,
    FUNC_ACK2    = 2'd2,
    FUNC_SUBACK  = 2'd3
  } pkt_func_t;

  // Classification of a passed-through byte.
  typedef enum logic [1:0] {
    BK_NONE    = 2'd0,
    BK_TOPIC   = 2'd1,
    BK_PAYLOAD = 2'd2,
    BK_RCODE   = 2'd3
  } byte_kind_t;

  // Packet status reported on the final result.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_BAD_QOS   = 3'd2,
    ST_BAD_TOPIC = 3'd3,
    ST_BAD_UTF8  = 3'd4,
    ST_BAD_ID    = 3'd5,
    ST_BAD_ARG   = 3'd6
  } status_t;

  // Protocol constants.
  localparam logic [7:0] CHAR_PLUS         = 8'h2B;
  localparam logic [7:0] CHAR_HASH         = 8'h23;
  localparam logic [7:0] SUBACK_FAILURE    = 8'h80;
  localparam logic [7:0] SUBACK_MAX_QOS    = 8'd2;
  localparam logic [7:0] CONNACK_MAX_CODE  = 8'd5;
  localparam logic [7:0] CONNACK_RSVD_MASK = 8'hFE;
  localparam logic [1:0] QOS_INVALID       = 2'd3;

  // Decoder state of the UTF-8 checker.
  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] partial;
    logic        bad;
  } utf8_state_t;

  // Input transaction payload.
  typedef struct packed {
    pkt_func_t  func;
    logic [3:0] header_flags;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    byte_kind_t  byte_kind;
    logic [7:0]  byte_out;
    status_t     status;
    logic [15:0] packet_ident;
    logic        sess_present;
    logic [7:0]  connect_code;
    logic        dup_flag;
    logic [1:0]  qos_level;
    logic        retain_flag;
    logic [15:0] topic_size;
    logic [27:0] body_count;
    logic        done_res;
  } out_t;

endpackage

@@ rtl/mvhp_utf8_step.sv @@
`timescale 1ns / 1ps

module mvhp_utf8_step import mvhp_pkg::*; (
  input  utf8_state_t cur,
  input  logic [7:0]  data_byte,
  output utf8_state_t nxt
);

  // One step of an RFC 3629 decoder: a lead byte opens a sequence, each
  // continuation byte shifts in six bits. Overlong forms, surrogates,
  // code points above U+10FFFF and U+0000 all mark the string bad.
  always_comb begin
    nxt = cur;
    if (cur.pending == 2'd0) begin
      if (data_byte < 8'h80) begin
        if (data_byte == 8'h00) begin
          nxt.bad = 1'b1;
        end
      end else if (data_byte < 8'hC2) begin
        nxt.bad = 1'b1;
      end else if (data_byte < 8'hE0) begin
        nxt.partial = {16'd0, data_byte[4:0]};
        nxt.pending = 2'd1;
      end else if (data_byte < 8'hF0) begin
        nxt.partial = {17'd0, data_byte[3:0]};
        nxt.pending = 2'd2;
      end else if (data_byte < 8'hF5) begin
        nxt.partial = {18'd0, data_byte[2:0]};
        nxt.pending = 2'd3;
      end else begin
        nxt.bad = 1'b1;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      // A sequence cut short by a non-continuation byte.
      nxt.bad     = 1'b1;
      nxt.pending = 2'd0;
    end else begin
      // Range checks on the first continuation byte.
      if (cur.pending == 2'd3) begin
        if (cur.partial == 21'd0 && data_byte < 8'h90) begin
          nxt.bad = 1'b1;
        end
        if (cur.partial == 21'd4 && data_byte >= 8'h90) begin
          nxt.bad = 1'b1;
        end
      end else if (cur.pending == 2'd2 && cur.partial < 21'd16) begin
        if (cur.partial == 21'd0 && data_byte < 8'hA0) begin
          nxt.bad = 1'b1;
        end
        if (cur.partial == 21'd13 && data_byte >= 8'hA0) begin
          nxt.bad = 1'b1;
        end
      end
      nxt.partial = {cur.partial[14:0], data_byte[5:0]};
      nxt.pending = cur.pending - 2'd1;
    end
  end

endmodule

@@ rtl/mqtt_variable_header_parser.sv @@
// Latency: the result of a transaction is valid in the cycle after it is accepted.
// Throughput: one input transaction per cycle while the output is not stalled; the
// per-packet registers and the single output register are updated together at each accepted byte.
// Reset (rst_n low, synchronous) clears all per-packet state and the output valid.
// The output register drains while a new transaction is taken in the same cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mqtt_variable_header_parser import mvhp_pkg::*; #(
  parameter int COUNT_BITS = 28
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Compare width: large enough for the position and for a 17-bit header size.
  localparam int CW = (COUNT_BITS > 17) ? COUNT_BITS : 17;
  localparam int EW = CW + 1;
  localparam logic [COUNT_BITS-1:0] POS_MAX = '1;
  localparam logic [COUNT_BITS-1:0] POS_ONE = COUNT_BITS'(1);

  logic [COUNT_BITS-1:0] pos_r, pos_nxt, pos_upd;
  logic [15:0] topic_rem_r, topic_rem_nxt, topic_rem_upd;
  logic [15:0] tlen_r, tlen_nxt, tlen_upd;
  logic [15:0] ident_r, ident_nxt, ident_upd;
  logic [7:0]  first_r, first_nxt, first_upd;
  logic        wild_r, wild_nxt, wild_upd;
  logic        err_r, err_nxt, err_upd;
  utf8_state_t utf_r, utf_nxt, utf_upd, utf_step;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, res;

  logic        in_accept;
  logic [7:0]  b;
  logic [1:0]  qos;
  logic        qos_on;
  byte_kind_t  kind;
  logic [16:0] hdr17;
  logic [EW-1:0] p_ext, hdr_ext, n_ext, hdrq_ext, body_diff;

  // Handshake: the output register frees itself whenever it is taken.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b      = in_data.data_byte;
  assign qos    = in_data.header_flags[2:1];
  assign qos_on = (qos != 2'd0);

  // Topic bytes are checked for well-formed UTF-8.
  mvhp_utf8_step u_utf8 (
    .cur       (utf_r),
    .data_byte (b),
    .nxt       (utf_step)
  );

  // Header size of a PUBLISH without the identifier, from the stored topic length.
  assign hdr17   = {1'b0, tlen_r} + 17'd2;
  assign p_ext   = EW'(pos_r);
  assign hdr_ext = EW'(hdr17);

  // Per-byte decode: position tracking and byte classification.
  always_comb begin
    pos_upd       = pos_r;
    topic_rem_upd = topic_rem_r;
    tlen_upd      = tlen_r;
    ident_upd     = ident_r;
    first_upd     = first_r;
    wild_upd      = wild_r;
    err_upd       = err_r;
    utf_upd       = utf_r;
    kind          = BK_NONE;
    if (in_data.has_byte) begin
      case (in_data.func)
        FUNC_PUBLISH: begin
          if (pos_r == '0) begin
            first_upd = b;
          end else if (pos_r == POS_ONE) begin
            tlen_upd      = {first_r, b};
            topic_rem_upd = {first_r, b};
          end else if (topic_rem_r != 16'd0) begin
            kind = BK_TOPIC;
            if (b == CHAR_PLUS || b == CHAR_HASH) begin
              wild_upd = 1'b1;
            end
            topic_rem_upd = topic_rem_r - 16'd1;
            utf_upd       = utf_step;
            // A topic must not end inside a multibyte sequence.
            if (topic_rem_r == 16'd1 && utf_step.pending != 2'd0) begin
              utf_upd.bad     = 1'b1;
              utf_upd.pending = 2'd0;
            end
          end else begin
            if (qos_on && p_ext == hdr_ext) begin
              first_upd = b;
            end else if (qos_on && p_ext == hdr_ext + EW'(1)) begin
              ident_upd = {first_r, b};
            end else begin
              kind = BK_PAYLOAD;
            end
          end
        end
        default: begin
          if (pos_r == '0) begin
            first_upd = b;
          end else if (pos_r == POS_ONE) begin
            ident_upd = {first_r, b};
          end else if (in_data.func == FUNC_SUBACK) begin
            kind = BK_RCODE;
            if (b > SUBACK_MAX_QOS && b != SUBACK_FAILURE) begin
              err_upd = 1'b1;
            end
          end
        end
      endcase
      pos_upd = (pos_r != POS_MAX) ? pos_r + POS_ONE : POS_MAX;
    end
  end

  // Sizes used by the packet summary, taken after this byte.
  assign n_ext    = EW'(pos_upd);
  assign hdrq_ext = EW'(tlen_upd) + EW'(2) + (qos_on ? EW'(2) : EW'(0));
  assign body_diff = (in_data.func == FUNC_SUBACK) ? (n_ext - EW'(2)) : (n_ext - hdrq_ext);

  // Result: the passed byte, and on the final byte the summary and status.
  always_comb begin
    res           = '0;
    res.byte_kind = kind;
    res.byte_out  = (kind != BK_NONE) ? b : 8'd0;
    if (in_data.last_byte) begin
      res.done_res = 1'b1;
      case (in_data.func)
        FUNC_CONNACK: begin
          if (n_ext != EW'(2) || (first_upd & CONNACK_RSVD_MASK) != 8'd0 ||
              ident_upd[7:0] > CONNACK_MAX_CODE) begin
            res.status = ST_MALFORMED;
          end
          res.sess_present = first_upd[0];
          res.connect_code = ident_upd[7:0];
        end
        FUNC_PUBLISH: begin
          if (n_ext == '0) begin
            res.status = ST_BAD_ARG;
          end else if (qos == QOS_INVALID) begin
            res.status = ST_BAD_QOS;
          end else if (n_ext < EW'(2) || topic_rem_upd != 16'd0) begin
            res.status = ST_MALFORMED;
          end else if (wild_upd) begin
            res.status = ST_BAD_TOPIC;
          end else if (utf_upd.bad) begin
            res.status = ST_BAD_UTF8;
          end else if (qos_on && n_ext < hdrq_ext) begin
            res.status = ST_MALFORMED;
          end else if (qos_on && ident_upd == 16'd0) begin
            res.status = ST_BAD_ID;
          end
          res.packet_ident = qos_on ? ident_upd : 16'd0;
          res.dup_flag     = in_data.header_flags[3];
          res.qos_level    = qos;
          res.retain_flag  = in_data.header_flags[0];
          res.topic_size   = tlen_upd;
          if (n_ext > hdrq_ext && n_ext >= EW'(2) && topic_rem_upd == 16'd0) begin
            res.body_count = 28'(body_diff);
          end
        end
        FUNC_ACK2: begin
          if (n_ext != EW'(2)) begin
            res.status = ST_MALFORMED;
          end else if (ident_upd == 16'd0) begin
            res.status = ST_BAD_ID;
          end
          res.packet_ident = ident_upd;
        end
        default: begin
          if (n_ext < EW'(3)) begin
            res.status = ST_BAD_ARG;
          end else if (ident_upd == 16'd0) begin
            res.status = ST_BAD_ID;
          end else if (err_upd) begin
            res.status = ST_MALFORMED;
          end
          res.packet_ident = ident_upd;
          if (n_ext >= EW'(2)) begin
            res.body_count = 28'(body_diff);
          end
        end
      endcase
    end
  end

  // The final byte of a packet clears every per-packet register.
  always_comb begin
    pos_nxt       = pos_upd;
    topic_rem_nxt = topic_rem_upd;
    tlen_nxt      = tlen_upd;
    ident_nxt     = ident_upd;
    first_nxt     = first_upd;
    wild_nxt      = wild_upd;
    err_nxt       = err_upd;
    utf_nxt       = utf_upd;
    if (in_data.last_byte) begin
      pos_nxt       = '0;
      topic_rem_nxt = '0;
      tlen_nxt      = '0;
      ident_nxt     = '0;
      first_nxt     = '0;
      wild_nxt      = 1'b0;
      err_nxt       = 1'b0;
      utf_nxt       = '0;
    end
  end

  // Output valid: set by an accepted transaction, cleared once taken.
  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Per-packet state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      topic_rem_r <= '0;
      tlen_r      <= '0;
      ident_r     <= '0;
      first_r     <= '0;
      wild_r      <= 1'b0;
      err_r       <= 1'b0;
      utf_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        pos_r       <= pos_nxt;
        topic_rem_r <= topic_rem_nxt;
        tlen_r      <= tlen_nxt;
        ident_r     <= ident_nxt;
        first_r     <= first_nxt;
        wild_r      <= wild_nxt;
        err_r       <= err_nxt;
        utf_r       <= utf_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res;
    end
  end

  `ASSERT_IMPL(a_plain_result_no_summary, out_valid_r && !out_data_r.done_res,
               out_data_r.status == ST_OK && out_data_r.packet_ident == 16'd0 &&
               out_data_r.body_count == 28'd0,
               "summary fields set on a result that is not final")
  `ASSERT_IMPL(a_idle_byte_zero, out_valid_r && out_data_r.byte_kind == BK_NONE,
               out_data_r.byte_out == 8'd0, "byte_out nonzero with no byte passed")
  `ASSERT_IMPL(a_utf8_closed_outside_topic, topic_rem_r == 16'd0,
               utf_r.pending == 2'd0, "UTF-8 sequence left open after the topic")
  `ASSERT_NEXT(a_last_clears_state, in_accept && in_data.last_byte,
               pos_r == '0 && tlen_r == 16'd0 && ident_r == 16'd0,
               "packet state not cleared after the final byte")

endmodule
